// ----- rtl/core/stlb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared types, constants and the double compare for the lower-bound search.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int KEY_W = 64;
    localparam int CNT_W = 11;
    localparam int POS_W = 10;

    localparam logic [0:0] MODE_LOAD  = 1'b0;
    localparam logic [0:0] MODE_QUERY = 1'b1;

    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic load_key;   // latch key, set up top probe
        logic probe;      // issue RAM read at current address
        logic first_cmp;  // evaluate check against last entry
        logic step;       // evaluate one binary-search step
        logic out_load;   // register result word
    } stlb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;      // entry count is zero
        logic above;      // key above last entry
        logic done;       // lo == hi
    } stlb_stat_t;

    // IEEE a <= b, false when either is NaN
    function automatic logic fle(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic r;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan) begin
            r = 1'b0;
        end else if (both_zero) begin
            r = 1'b1;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (a[63]) begin
            r = (a[62:0] >= b[62:0]);
        end else begin
            r = (a[62:0] <= b[62:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stlb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stlb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/stlb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_datapath
// Key register, lo/hi bounds, probe address and table RAM.
// ----------------------------------------------------------------------------
module stlb_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [stlb_pkg::POS_W-1:0]  wr_idx,
    input  wire logic [stlb_pkg::KEY_W-1:0]  in_key,
    input  wire logic [stlb_pkg::CNT_W-1:0]  entry_count,
    input  wire stlb_pkg::stlb_cmd_t         cmd,
    output stlb_pkg::stlb_stat_t             stat,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_found,
    output logic [stlb_pkg::POS_W-1:0]       m_position
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    logic [stlb_pkg::KEY_W-1:0] key_reg;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next, addr;
    logic [NW-1:0] n_sat;
    logic [stlb_pkg::KEY_W-1:0] rdata;
    logic le;
    logic above_reg;
    logic valid_reg;
    logic found_reg;
    logic [stlb_pkg::POS_W-1:0] pos_reg;
    logic wr_ok;

    // saturate count to depth
    always_comb begin
        logic [NW:0] c;
        c = (NW+1)'(entry_count);
        if (c > (NW+1)'(TABLE_DEPTH)) begin
            n_sat = NW'(TABLE_DEPTH);
        end else begin
            n_sat = c[NW-1:0];
        end
    end

    assign wr_ok = ((NW+1)'(wr_idx) < (NW+1)'(TABLE_DEPTH)) && wr_en;
    assign addr  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign le    = stlb_pkg::fle(key_reg, rdata);

    stlb_ram #(.WIDTH(stlb_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (wr_ok),
        .waddr (AW'(wr_idx)),
        .wdata (in_key),
        .re    (cmd.probe),
        .raddr (cmd.load_key ? AW'(n_sat - NW'(1)) : addr),
        .rdata (rdata)
    );

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load_key) begin
            lo_next = '0;
            hi_next = AW'(n_sat - NW'(1));
        end else if (cmd.step) begin
            if (le) begin
                hi_next = addr;
            end else begin
                lo_next = addr + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.load_key) begin
            key_reg   <= in_key;
            above_reg <= 1'b0;
        end
        // key > last: last <= key and not key <= last; false with any NaN
        if (cmd.first_cmp) begin
            above_reg <= !le && stlb_pkg::fle(rdata, key_reg);
        end
        if (cmd.out_load) begin
            found_reg <= !(n_sat == '0) && !above_reg;
            pos_reg   <= ((n_sat == '0) || above_reg) ? '0 : stlb_pkg::POS_W'(lo_reg);
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign stat.empty = (n_sat == '0);
    assign stat.above = above_reg;
    assign stat.done  = (lo_reg == hi_reg);

    assign m_valid    = valid_reg;
    assign m_found    = found_reg;
    assign m_position = pos_reg;
endmodule
`default_nettype wire

// ----- rtl/core/stlb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_ctrl
// Sequencer for load and query words.
// ----------------------------------------------------------------------------
module stlb_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire stlb_pkg::stlb_stat_t stat,
    output stlb_pkg::stlb_cmd_t       cmd,
    output logic                      wr_en
);
    typedef enum logic [2:0] {ST_IDLE, ST_LAST, ST_CHECK, ST_PROBE, ST_STEP, ST_OUT} state_t;
    state_t state_reg;

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_mode == stlb_pkg::MODE_LOAD);

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_key = accept && (s_mode == stlb_pkg::MODE_QUERY);
                cmd.probe    = cmd.load_key;
            end
            ST_LAST:  cmd.first_cmp = 1'b1;
            ST_CHECK: cmd.probe = !stat.empty && !stat.above && !stat.done;
            ST_PROBE: cmd.probe = 1'b0;
            ST_STEP:  cmd.step = 1'b1;
            ST_OUT:   cmd.out_load = !m_valid || m_ready;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (cmd.load_key) begin
                    state_reg <= ST_LAST;
                end
                ST_LAST:  state_reg <= ST_CHECK;
                ST_CHECK: begin
                    if (cmd.probe) begin
                        state_reg <= ST_STEP;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_PROBE: state_reg <= ST_STEP;
                ST_STEP:  state_reg <= ST_CHECK;
                ST_OUT:   if (cmd.out_load) begin
                    state_reg <= ST_IDLE;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/sorted_table_lower_bound_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search
// Lower-bound binary search over a RAM table of IEEE double keys.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  s_      | s_valid/s_ready, mode, index, key  | load or query word
//  m_      | m_valid/m_ready, found, position   | one result word per query
//  apb     | psel..pready                       | entry_count at 0x0
//
//  Load: RAM write at accept.
//  Query: each search step is one RAM read (registered) then one compare.
//  Reset clears control state and entry_count; table contents undefined.
//  A full result register holds the sequencer in its output state.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [9:0]  s_entry_index,
    input  wire logic [63:0] s_key_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [9:0]       m_position,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [stlb_pkg::CNT_W-1:0] count_reg;
    stlb_pkg::stlb_cmd_t  cmd;
    stlb_pkg::stlb_stat_t stat;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == stlb_pkg::REG_ENTRY_COUNT) && (paddr[1:0] == 2'b00);
    assign prdata  = reg_sel ? 32'(count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            count_reg <= pwdata[stlb_pkg::CNT_W-1:0];
        end
    end

    stlb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .wr_en   (wr_en)
    );

    stlb_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_idx      (s_entry_index),
        .in_key      (s_key_bits),
        .entry_count (count_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_position  (m_position)
    );

    // a held result word must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_found) && $stable(m_position))
        else $error("result changed while stalled");
    // no input taken while a search is in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_key |=> !s_ready)
        else $error("input accepted mid-search");
    // not-found results report position zero
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_position == '0)
        else $error("not-found with nonzero position");

endmodule
`default_nettype wire
